FILE: sv/eet_pkg.sv
// Shared constants and codes for the eased event timeline unit.
package eet_pkg;

    localparam int DEF_MAX_EVENTS = 16;
    localparam int DEF_TIME_BITS  = 32;

    // Q1.15 progress scale.
    localparam int ONE_Q  = 32768;
    localparam int HALF_Q = 16384;
    localparam int Q_FRAC = 15;

    // Result buffer for one input word.
    localparam int RES_CAP = 32;
    localparam int BIW     = $clog2(RES_CAP);
    localparam int BCW     = $clog2(RES_CAP + 1);

    localparam logic [2:0] OP_ADD     = 3'd0;
    localparam logic [2:0] OP_GAP     = 3'd1;
    localparam logic [2:0] OP_WAIT    = 3'd2;
    localparam logic [2:0] OP_ADVANCE = 3'd3;
    localparam logic [2:0] OP_SCRUB   = 3'd4;

    localparam logic [2:0] EASE_LINEAR    = 3'd0;
    localparam logic [2:0] EASE_QUAD_IN   = 3'd1;
    localparam logic [2:0] EASE_QUAD_OUT  = 3'd2;
    localparam logic [2:0] EASE_QUAD_OI   = 3'd3;
    localparam logic [2:0] EASE_CUBIC     = 3'd4;
    localparam logic [2:0] EASE_CUBIC_FLT = 3'd5;
    localparam logic [2:0] EASE_FLASH     = 3'd6;

endpackage

FILE: sv/eased_event_timeline_unit.sv
// Top level of the eased event timeline unit: event table, sequencer, divider and easing.
//
// The unit works on one input word at a time and takes the next only after every
// result word of the current one has been taken. Add, gap and wait write the table
// and then give their status word. Advance and scrub visit events one by one: an
// activation check reads each pending event, and each event that runs passes through
// table and active-list reads, the bit-serial divider when its progress lies strictly
// inside the event, and the easing multiplier pipeline. Results are collected in a
// 32-word buffer, because the at-end flag is known only when the whole input has been
// processed, and then leave one word at a time, each held until it is taken.
module eased_event_timeline_unit
    import eet_pkg::*;
#(
    parameter int MAX_EVENTS = DEF_MAX_EVENTS,
    parameter int TIME_BITS  = DEF_TIME_BITS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [2:0]  i_operation,
    input  logic [31:0] i_duration,
    input  logic [2:0]  i_ease_mode,
    input  logic        i_has_action,
    input  logic [31:0] i_time_value,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [3:0]  o_event_index,
    output logic [15:0] o_progress,
    output logic        o_at_end,
    output logic        o_error,
    output logic        o_last
);

    localparam int IW = (MAX_EVENTS > 1) ? $clog2(MAX_EVENTS) : 1;
    localparam int CW = $clog2(MAX_EVENTS + 1);
    localparam int TB = TIME_BITS;
    localparam int WW = (TB > 32) ? TB : 32;
    localparam logic [TB-1:0] TMAX = {TB{1'b1}};

    typedef struct packed {
        logic [TB-1:0] st;
        logic [TB-1:0] en;
        logic [2:0]    ease;
        logic          act;
    } t_entry;

    typedef enum logic [4:0] {
        S_IDLE, S_ADD_WR,
        S_UPA_RD, S_UPA_CHK, S_UPB_RD, S_UPB_EV, S_UPB_CHK, S_UPB_NX,
        S_DN1_RD, S_DN1_CHK, S_DN1_NX, S_DN2_RD, S_DN2_CHK, S_DN2_NX,
        S_DIV, S_EASE0, S_EASE1, S_EASE2, S_EASE3,
        S_FIN, S_DR_RD, S_DR_LD, S_DR_OUT
    } t_state;

    function automatic logic [TB-1:0] sat_in(input logic [31:0] v);
        logic [WW-1:0] w;
        w = WW'(v);
        if (w > WW'(TMAX)) return TMAX;
        return w[TB-1:0];
    endfunction

    function automatic logic [TB-1:0] sat_add(input logic [TB-1:0] a, input logic [TB-1:0] b);
        logic [TB:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[TB] ? TMAX : s[TB-1:0];
    endfunction

    function automatic logic [3:0] idx4(input logic [IW-1:0] v);
        logic [IW+3:0] t;
        t = {4'b0, v};
        return t[3:0];
    endfunction

    t_entry        r_tab_mem [MAX_EVENTS];
    logic [IW-1:0] r_act_mem [MAX_EVENTS];
    logic [19:0]   r_buf_mem [RES_CAP];
    t_entry        r_tab_rd;
    logic [IW-1:0] r_act_rd;
    logic [19:0]   r_buf_rd;

    t_state        r_state, r_ret;
    logic [2:0]    r_op;
    logic [TB-1:0] r_dur, r_t, r_tp, r_total;
    logic [CW-1:0] r_ec, r_np, r_ac, r_i, r_w;
    logic          r_err, r_brk, r_neg;
    logic [IW-1:0] r_sidx, r_ev;
    logic [2:0]    r_emode;
    logic [TB:0]   r_rem;
    logic [TB-1:0] r_dvs;
    logic [14:0]   r_q;
    logic [3:0]    r_dcnt;
    logic [15:0]   r_x, r_a;
    logic [31:0]   r_sq;
    logic [47:0]   r_cube;
    logic [BCW-1:0] r_bcnt, r_rp;
    logic          r_o_valid, r_o_aend, r_o_err, r_o_last;
    logic [3:0]    r_o_idx;
    logic [15:0]   r_o_prog;

    // Ease mode and action flag of an added event, captured with the word.
    logic [2:0]    r_mode;
    logic          r_act;

    logic [TB-1:0] c_dur_in, c_tv_in, c_adv_t, c_ps, c_pe, c_len;
    logic [CW-1:0] c_npm1, c_ecm1;
    logic          c_at_end, c_full, c_zero;
    logic [TB:0]   c_rem2;
    logic          c_ge;
    logic [14:0]   c_qn;
    logic [16:0]   c_2x, c_m, c_res;
    logic [33:0]   c_sq_r1, c_sq_r2;
    logic [47:0]   c_cu4, c_cu5;

    assign c_dur_in = sat_in(i_duration);
    assign c_tv_in  = sat_in(i_time_value);
    assign c_adv_t  = sat_add(r_tp, c_tv_in);
    assign c_npm1   = r_np - CW'(1);
    assign c_ecm1   = r_ec - CW'(1);
    assign c_at_end = (r_np == r_ec) && (r_ac == '0);
    assign c_ps     = (r_ec == '0) ? '0 : r_tab_rd.st;
    assign c_pe     = (r_ec == '0) ? '0 : r_tab_rd.en;
    assign c_len    = (c_pe >= c_ps) ? (c_pe - c_ps) : '0;

    // Progress outside the open interval needs no division.
    assign c_full = (r_tab_rd.en <= r_tab_rd.st) || (r_t >= r_tab_rd.en);
    assign c_zero = (r_t <= r_tab_rd.st);

    assign c_rem2 = {r_rem[TB-1:0], 1'b0};
    assign c_ge   = (c_rem2 >= {1'b0, r_dvs});
    assign c_qn   = {r_q[13:0], c_ge};

    assign c_2x = {r_x, 1'b0};
    assign c_m  = (r_x < 16'(HALF_Q)) ? (17'(ONE_Q) - c_2x) : (c_2x - 17'(ONE_Q));

    assign c_sq_r1 = ({2'b0, r_sq} + 34'(HALF_Q)) >> Q_FRAC;
    assign c_sq_r2 = ({1'b0, r_sq, 1'b0} + 34'(HALF_Q)) >> Q_FRAC;
    assign c_cu4   = (r_cube + 48'h0000_4000_0000) >> 31;
    assign c_cu5   = ({2'b0, r_a, 30'b0} + r_cube + 48'h0000_8000_0000) >> 32;

    always_comb begin
        case (r_emode)
            EASE_QUAD_IN:   c_res = 17'(ONE_Q) - c_sq_r1[16:0];
            EASE_QUAD_OUT:  c_res = c_sq_r1[16:0];
            EASE_QUAD_OI:   c_res = (r_x < 16'(HALF_Q)) ? c_sq_r2[16:0]
                                                        : 17'(ONE_Q) - c_sq_r2[16:0];
            EASE_CUBIC:     c_res = r_neg ? 17'(HALF_Q) - c_cu4[16:0]
                                          : 17'(HALF_Q) + c_cu4[16:0];
            EASE_CUBIC_FLT: c_res = r_neg ? 17'(HALF_Q) - c_cu5[16:0]
                                          : 17'(HALF_Q) + c_cu5[16:0];
            EASE_FLASH:     c_res = (r_x != '0) ? 17'(ONE_Q) - {1'b0, r_x} : '0;
            default:        c_res = {1'b0, r_x};
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_ret     <= S_IDLE;
            r_ec      <= '0;
            r_np      <= '0;
            r_ac      <= '0;
            r_tp      <= '0;
            r_total   <= '0;
            r_bcnt    <= '0;
            r_rp      <= '0;
            r_o_valid <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_op   <= i_operation;
                        r_dur  <= c_dur_in;
                        r_err  <= 1'b0;
                        r_sidx <= '0;
                        r_bcnt <= '0;
                        r_rp   <= '0;
                        if (i_operation <= OP_WAIT) begin
                            if ((i_operation == OP_WAIT && r_ec == '0) ||
                                r_ec >= CW'(MAX_EVENTS)) begin
                                r_err   <= 1'b1;
                                r_state <= S_FIN;
                            end else begin
                                r_sidx   <= r_ec[IW-1:0];
                                r_tab_rd <= r_tab_mem[c_ecm1[IW-1:0]];
                                r_state  <= S_ADD_WR;
                            end
                        end else if (i_operation == OP_ADVANCE) begin
                            r_t     <= c_adv_t;
                            r_state <= c_at_end ? S_FIN : S_UPA_RD;
                        end else if (i_operation == OP_SCRUB) begin
                            r_t <= c_tv_in;
                            if (c_tv_in > r_tp) begin
                                r_state <= S_UPA_RD;
                            end else begin
                                r_ac    <= '0;
                                r_state <= S_DN1_RD;
                            end
                        end else begin
                            r_state <= S_FIN;
                        end
                    end
                end
                S_ADD_WR: begin
                    case (r_op)
                        OP_ADD: begin
                            r_tab_mem[r_ec[IW-1:0]] <= '{st: c_ps, en: sat_add(c_ps, r_dur),
                                                         ease: r_mode, act: r_act};
                            r_total <= sat_add(c_ps, r_dur);
                        end
                        OP_GAP: begin
                            r_tab_mem[r_ec[IW-1:0]] <= '{st: sat_add(c_ps, r_dur),
                                                         en: sat_add(c_ps, r_dur),
                                                         ease: EASE_LINEAR, act: 1'b0};
                            r_total <= sat_add(c_ps, r_dur);
                        end
                        default: begin
                            r_tab_mem[r_ec[IW-1:0]] <= '{st: sat_add(c_ps, c_len),
                                                         en: sat_add(c_ps, c_len),
                                                         ease: EASE_LINEAR, act: 1'b0};
                            r_total <= sat_add(c_ps, c_len);
                        end
                    endcase
                    r_ec    <= r_ec + CW'(1);
                    r_state <= S_FIN;
                end
                S_UPA_RD: begin
                    if (r_np < r_ec) begin
                        r_tab_rd <= r_tab_mem[r_np[IW-1:0]];
                        r_state  <= S_UPA_CHK;
                    end else begin
                        r_i     <= '0;
                        r_w     <= '0;
                        r_state <= S_UPB_RD;
                    end
                end
                S_UPA_CHK: begin
                    if (r_t >= r_tab_rd.st) begin
                        if (r_ac < CW'(MAX_EVENTS)) begin
                            r_act_mem[r_ac[IW-1:0]] <= r_np[IW-1:0];
                            r_ac <= r_ac + CW'(1);
                        end
                        r_np    <= r_np + CW'(1);
                        r_state <= S_UPA_RD;
                    end else begin
                        r_i     <= '0;
                        r_w     <= '0;
                        r_state <= S_UPB_RD;
                    end
                end
                S_UPB_RD: begin
                    if (r_i < r_ac) begin
                        r_act_rd <= r_act_mem[r_i[IW-1:0]];
                        r_state  <= S_UPB_EV;
                    end else begin
                        r_ac    <= r_w;
                        r_tp    <= (r_np == r_ec && r_w == '0) ? r_total : r_t;
                        r_state <= S_FIN;
                    end
                end
                S_UPB_EV: begin
                    r_ev     <= r_act_rd;
                    r_tab_rd <= r_tab_mem[r_act_rd];
                    r_state  <= S_UPB_CHK;
                end
                S_UPB_CHK: begin
                    r_emode <= r_tab_rd.ease;
                    r_ret   <= S_UPB_NX;
                    // Retired events drop out; the rest are packed down in place.
                    if (r_t <= r_tab_rd.en) begin
                        r_act_mem[r_w[IW-1:0]] <= r_ev;
                        r_w <= r_w + CW'(1);
                    end
                    if (!r_tab_rd.act) begin
                        r_state <= S_UPB_NX;
                    end else if (r_t > r_tab_rd.en || c_full) begin
                        r_x     <= 16'(ONE_Q);
                        r_state <= S_EASE0;
                    end else if (c_zero) begin
                        r_x     <= '0;
                        r_state <= S_EASE0;
                    end else begin
                        r_rem   <= {1'b0, r_t - r_tab_rd.st};
                        r_dvs   <= r_tab_rd.en - r_tab_rd.st;
                        r_q     <= '0;
                        r_dcnt  <= 4'(Q_FRAC - 1);
                        r_state <= S_DIV;
                    end
                end
                S_UPB_NX: begin
                    r_i     <= r_i + CW'(1);
                    r_state <= S_UPB_RD;
                end
                S_DN1_RD: begin
                    if (r_np != '0) begin
                        r_ev     <= c_npm1[IW-1:0];
                        r_tab_rd <= r_tab_mem[c_npm1[IW-1:0]];
                        r_state  <= S_DN1_CHK;
                    end else begin
                        r_i     <= '0;
                        r_state <= S_DN2_RD;
                    end
                end
                S_DN1_CHK: begin
                    r_brk   <= (r_t > r_tab_rd.st);
                    r_emode <= r_tab_rd.ease;
                    r_ret   <= S_DN1_NX;
                    r_x     <= '0;
                    if (!(r_t > r_tab_rd.st)) r_np <= c_npm1;
                    r_state <= r_tab_rd.act ? S_EASE0 : S_DN1_NX;
                end
                S_DN1_NX: begin
                    if (r_brk) begin
                        r_i     <= '0;
                        r_state <= S_DN2_RD;
                    end else begin
                        r_state <= S_DN1_RD;
                    end
                end
                S_DN2_RD: begin
                    if (r_i < r_np) begin
                        r_ev     <= r_i[IW-1:0];
                        r_tab_rd <= r_tab_mem[r_i[IW-1:0]];
                        r_state  <= S_DN2_CHK;
                    end else begin
                        r_tp    <= r_t;
                        r_state <= S_FIN;
                    end
                end
                S_DN2_CHK: begin
                    r_emode <= r_tab_rd.ease;
                    r_ret   <= S_DN2_NX;
                    if (r_t >= r_tab_rd.st && r_t < r_tab_rd.en) begin
                        if (r_ac < CW'(MAX_EVENTS)) begin
                            r_act_mem[r_ac[IW-1:0]] <= r_ev;
                            r_ac <= r_ac + CW'(1);
                        end
                        if (!r_tab_rd.act) begin
                            r_state <= S_DN2_NX;
                        end else if (c_zero) begin
                            r_x     <= '0;
                            r_state <= S_EASE0;
                        end else begin
                            r_rem   <= {1'b0, r_t - r_tab_rd.st};
                            r_dvs   <= r_tab_rd.en - r_tab_rd.st;
                            r_q     <= '0;
                            r_dcnt  <= 4'(Q_FRAC - 1);
                            r_state <= S_DIV;
                        end
                    end else begin
                        r_state <= S_DN2_NX;
                    end
                end
                S_DN2_NX: begin
                    r_i     <= r_i + CW'(1);
                    r_state <= S_DN2_RD;
                end
                S_DIV: begin
                    // Restoring division, one quotient bit per cycle; the remainder
                    // always stays below the divisor.
                    r_rem <= c_ge ? (c_rem2 - {1'b0, r_dvs}) : c_rem2;
                    r_q   <= c_qn;
                    if (r_dcnt == '0) begin
                        r_x     <= {1'b0, c_qn};
                        r_state <= S_EASE0;
                    end else begin
                        r_dcnt <= r_dcnt - 4'd1;
                    end
                end
                S_EASE0: begin
                    r_neg <= (r_x < 16'(HALF_Q));
                    case (r_emode)
                        EASE_QUAD_IN:   r_a <= 16'(ONE_Q) - r_x;
                        EASE_QUAD_OI:   r_a <= (r_x < 16'(HALF_Q)) ? r_x : 16'(ONE_Q) - r_x;
                        EASE_CUBIC:     r_a <= c_m[15:0];
                        EASE_CUBIC_FLT: r_a <= c_m[15:0];
                        default:        r_a <= r_x;
                    endcase
                    r_state <= S_EASE1;
                end
                S_EASE1: begin
                    r_sq    <= r_a * r_a;
                    r_state <= S_EASE2;
                end
                S_EASE2: begin
                    r_cube  <= r_sq * {16'b0, r_a};
                    r_state <= S_EASE3;
                end
                S_EASE3: begin
                    if (r_bcnt < BCW'(RES_CAP)) begin
                        r_buf_mem[r_bcnt[BIW-1:0]] <= {idx4(r_ev), c_res[15:0]};
                        r_bcnt <= r_bcnt + BCW'(1);
                    end
                    r_state <= r_ret;
                end
                S_FIN: begin
                    if (r_bcnt == '0) begin
                        r_buf_mem[0] <= {idx4(r_sidx), 16'b0};
                        r_bcnt       <= BCW'(1);
                    end
                    r_o_aend <= c_at_end;
                    r_state  <= S_DR_RD;
                end
                S_DR_RD: begin
                    r_buf_rd <= r_buf_mem[r_rp[BIW-1:0]];
                    r_state  <= S_DR_LD;
                end
                S_DR_LD: begin
                    r_o_valid <= 1'b1;
                    r_o_idx   <= r_buf_rd[19:16];
                    r_o_prog  <= r_buf_rd[15:0];
                    r_o_err   <= r_err;
                    r_o_last  <= (r_rp + BCW'(1) == r_bcnt);
                    r_state   <= S_DR_OUT;
                end
                S_DR_OUT: begin
                    if (i_ready) begin
                        r_o_valid <= 1'b0;
                        r_rp      <= r_rp + BCW'(1);
                        r_state   <= r_o_last ? S_IDLE : S_DR_RD;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_valid) begin
            r_mode <= i_ease_mode;
            r_act  <= i_has_action;
        end
    end

    assign o_ready       = (r_state == S_IDLE);
    assign o_valid       = r_o_valid;
    assign o_event_index = r_o_idx;
    assign o_progress    = r_o_prog;
    assign o_at_end      = r_o_aend;
    assign o_error       = r_o_err;
    assign o_last        = r_o_last;

endmodule

FILE: sv/eet_chk.sv
// Port-level checker for the eased event timeline unit, with its bind statement.
module eet_chk
    import eet_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_ready,
    input logic [2:0]  i_operation,
    input logic [31:0] i_duration,
    input logic [2:0]  i_ease_mode,
    input logic        i_has_action,
    input logic [31:0] i_time_value,
    input logic        o_valid,
    input logic        i_ready,
    input logic [3:0]  o_event_index,
    input logic [15:0] o_progress,
    input logic        o_at_end,
    input logic        o_error,
    input logic        o_last
);

    // A stalled result word holds.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_progress) && $stable(o_event_index)
                                && $stable(o_last))
        else $error("result word changed while stalled");

    // Input is taken only when no result of the previous word is pending.
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ready |-> !o_valid)
        else $error("input ready while results pending");

    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("accepted word did not occupy the unit");

    // An error comes only as the lone status word.
    a_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_error |-> o_last && o_progress == 16'd0)
        else $error("error flag on a progress word");

    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_progress <= 16'(ONE_Q))
        else $error("progress above one");

endmodule

bind eased_event_timeline_unit eet_chk u_eet_chk (.*);

FILE: dv/tb.sv
// Self-checking testbench for the eased event timeline unit.
module tb
    import eet_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int          EVENT_SLOTS = 16;
    localparam logic [63:0] TICK_MAX    = 64'hFFFF_FFFF;
    localparam logic [2:0]  OP_SPARE5   = 3'd5;
    localparam logic [2:0]  OP_SPARE6   = 3'd6;
    localparam logic [2:0]  OP_SPARE7   = 3'd7;
    localparam logic [2:0]  EASE_SPARE  = 3'd7;
    localparam int          CYCLE_LIMIT = 2000000;

    typedef struct packed {
        logic [3:0]  event_index;
        logic [15:0] progress;
        logic        at_end;
        logic        error;
        logic        last;
    } t_progress_word;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic [2:0]  i_operation;
    logic [31:0] i_duration;
    logic [2:0]  i_ease_mode;
    logic        i_has_action;
    logic [31:0] i_time_value;
    logic        o_valid;
    logic        i_ready;
    logic [3:0]  o_event_index;
    logic [15:0] o_progress;
    logic        o_at_end;
    logic        o_error;
    logic        o_last;

    eased_event_timeline_unit DUT (.*);

    // Timeline shadow state.
    logic [63:0] ev_start [EVENT_SLOTS];
    logic [63:0] ev_end [EVENT_SLOTS];
    logic [2:0]  ev_ease [EVENT_SLOTS];
    bit          ev_act [EVENT_SLOTS];
    int          live_ids [EVENT_SLOTS];
    int          n_events;
    int          next_pend;
    int          n_live;
    logic [63:0] now_tick;
    logic [63:0] total_ticks;

    t_progress_word step_words[$];
    t_progress_word expected_words[$];

    int  fails = 0;
    int  words_checked = 0;
    int  words_sent;
    int  error_words;
    int  cycles = 0;
    bit  calm;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb: FAIL");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        i_ready <= calm ? 1'b1 : ($urandom_range(0, 99) >= 14);
    end

    function automatic logic [63:0] sat_tick(logic [63:0] v);
        return v > TICK_MAX ? TICK_MAX : v;
    endfunction

    function automatic logic [63:0] eased(logic [2:0] mode, logic [63:0] x);
        logic [63:0] m;
        logic [63:0] r;
        bit          lower;
        case (mode)
            EASE_QUAD_IN: begin
                r = ((ONE_Q - x) * (ONE_Q - x) + 64'd16384) >> 15;
                return ONE_Q - r;
            end
            EASE_QUAD_OUT: return (x * x + 64'd16384) >> 15;
            EASE_QUAD_OI: begin
                if (x < HALF_Q) return (2 * x * x + 64'd16384) >> 15;
                r = (2 * (ONE_Q - x) * (ONE_Q - x) + 64'd16384) >> 15;
                return ONE_Q - r;
            end
            EASE_CUBIC, EASE_CUBIC_FLT: begin
                lower = (2 * x) < ONE_Q;
                m = lower ? ONE_Q - 2 * x : 2 * x - ONE_Q;
                if (mode == EASE_CUBIC) r = (m * m * m + (64'd1 << 30)) >> 31;
                else r = ((m << 30) + m * m * m + (64'd1 << 31)) >> 32;
                return lower ? HALF_Q - r : HALF_Q + r;
            end
            EASE_FLASH: return x > 0 ? ONE_Q - x : 64'd0;
            default: return x;
        endcase
    endfunction

    function automatic void note_progress(int idx, logic [63:0] x);
        t_progress_word w;
        logic [63:0]    v;
        if (!ev_act[idx] || step_words.size() >= RES_CAP) return;
        w = '0;
        w.event_index = idx[3:0];
        v = eased(ev_ease[idx], x);
        w.progress = v[15:0];
        step_words.push_back(w);
    endfunction

    function automatic logic [63:0] fraction_at(int idx, logic [63:0] t);
        logic [63:0] s;
        logic [63:0] e;
        s = ev_start[idx];
        e = ev_end[idx];
        if (e <= s || t >= e) return ONE_Q;
        if (t <= s) return 0;
        return ((t - s) << 15) / (e - s);
    endfunction

    function automatic bit timeline_done();
        return next_pend == n_events && n_live == 0;
    endfunction

    function automatic void seek_forward(logic [63:0] t);
        int i;
        int ev;
        while (next_pend < n_events && t >= ev_start[next_pend]) begin
            if (n_live < EVENT_SLOTS) begin
                live_ids[n_live] = next_pend;
                n_live++;
            end
            next_pend++;
        end
        i = 0;
        while (i < n_live) begin
            ev = live_ids[i];
            if (t > ev_end[ev]) begin
                note_progress(ev, ONE_Q);
                for (int k = i; k + 1 < n_live; k++) live_ids[k] = live_ids[k + 1];
                n_live--;
            end else begin
                note_progress(ev, fraction_at(ev, t));
                i++;
            end
        end
        now_tick = timeline_done() ? total_ticks : t;
    endfunction

    function automatic void seek_backward(logic [63:0] t);
        int ev;
        n_live = 0;
        for (int i = next_pend; i > 0; i--) begin
            ev = i - 1;
            note_progress(ev, 0);
            if (t > ev_start[ev]) break;
            next_pend = ev;
        end
        for (int i = 0; i < next_pend; i++) begin
            if (t >= ev_start[i] && t < ev_end[i]) begin
                note_progress(i, fraction_at(i, t));
                if (n_live < EVENT_SLOTS) begin
                    live_ids[n_live] = i;
                    n_live++;
                end
            end
        end
        now_tick = t;
    endfunction

    function automatic bit push_event(logic [63:0] s, logic [63:0] e, logic [2:0] mode, bit act);
        if (n_events >= EVENT_SLOTS) return 0;
        ev_start[n_events] = s;
        ev_end[n_events] = e;
        ev_ease[n_events] = mode;
        ev_act[n_events] = act;
        n_events++;
        total_ticks = e;
        return 1;
    endfunction

    function automatic bit push_marker(logic [63:0] d);
        logic [63:0] s;
        s = n_events == 0 ? d : sat_tick(ev_start[n_events - 1] + d);
        return push_event(s, s, EASE_LINEAR, 0);
    endfunction

    // Works out every result word that one input word produces.
    function automatic void predict_word(logic [2:0] op, logic [31:0] dur, logic [2:0] mode,
                                         bit act, logic [31:0] tv);
        bit          failed;
        int          status_idx;
        logic [63:0] s;
        logic [63:0] len;
        bit          done;
        t_progress_word w;
        failed = 0;
        status_idx = 0;
        step_words.delete();
        if (op == OP_ADD || op == OP_GAP || op == OP_WAIT) begin
            status_idx = n_events;
            if (op == OP_ADD) begin
                s = n_events == 0 ? 64'd0 : ev_start[n_events - 1];
                failed = !push_event(s, sat_tick(s + dur), mode, act);
            end else if (op == OP_GAP) begin
                failed = !push_marker(dur);
            end else if (n_events == 0) begin
                failed = 1;
            end else begin
                len = ev_end[n_events - 1] >= ev_start[n_events - 1] ?
                      ev_end[n_events - 1] - ev_start[n_events - 1] : 64'd0;
                failed = !push_marker(len);
            end
            if (failed) status_idx = 0;
        end else if (op == OP_ADVANCE) begin
            if (!timeline_done()) seek_forward(sat_tick(now_tick + tv));
        end else if (op == OP_SCRUB) begin
            if (tv > now_tick) seek_forward(tv);
            else seek_backward(tv);
        end
        if (step_words.size() == 0) begin
            w = '0;
            w.event_index = status_idx[3:0];
            w.error = failed;
            step_words.push_back(w);
        end
        done = timeline_done();
        foreach (step_words[k]) begin
            w = step_words[k];
            w.at_end = done;
            w.last = (k == step_words.size() - 1);
            if (w.error) error_words++;
            expected_words.push_back(w);
        end
    endfunction

    task automatic send_word(logic [2:0] op, logic [31:0] dur, logic [2:0] mode, bit act,
                             logic [31:0] tv);
        while (!calm && $urandom_range(0, 99) < 14) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_operation <= op;
        i_duration <= dur;
        i_ease_mode <= mode;
        i_has_action <= act;
        i_time_value <= tv;
        do @(posedge i_clk); while (!o_ready);
        predict_word(op, dur, mode, act, tv);
        words_sent++;
    endtask

    always @(posedge i_clk) begin
        t_progress_word want;
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_words.size() == 0) begin
                $error("unexpected result word: index %0d progress %0d", o_event_index,
                       o_progress);
                fails++;
            end else begin
                want = expected_words.pop_front();
                words_checked++;
                if (o_event_index !== want.event_index) begin
                    $error("event_index: expected %0d, got %0d", want.event_index,
                           o_event_index);
                    fails++;
                end
                if (o_progress !== want.progress) begin
                    $error("progress: expected %0d, got %0d", want.progress, o_progress);
                    fails++;
                end
                if (o_at_end !== want.at_end) begin
                    $error("at_end: expected %0d, got %0d", want.at_end, o_at_end);
                    fails++;
                end
                if (o_error !== want.error) begin
                    $error("error: expected %0d, got %0d", want.error, o_error);
                    fails++;
                end
                if (o_last !== want.last) begin
                    $error("last: expected %0d, got %0d", want.last, o_last);
                    fails++;
                end
            end
        end
    end

    // Empty timeline: wait fails, ticks do nothing, spare codes are ignored.
    task automatic test_empty_timeline();
        send_word(OP_WAIT, 32'd5, EASE_LINEAR, 1'b1, 32'd0);
        send_word(OP_ADVANCE, 32'd0, EASE_LINEAR, 1'b0, 32'd10);
        send_word(OP_SCRUB, 32'd0, EASE_LINEAR, 1'b0, 32'd0);
        send_word(OP_SPARE5, 32'hFFFF_FFFF, EASE_SPARE, 1'b1, 32'hFFFF_FFFF);
        send_word(OP_SPARE6, 32'd0, EASE_LINEAR, 1'b0, 32'd0);
        send_word(OP_SPARE7, 32'd3, EASE_FLASH, 1'b1, 32'd3);
    endtask

    // One event per ease code, a zero-length one, a gap, a wait and an event without action.
    task automatic test_build_timeline();
        for (int m = 0; m < 8; m++)
            send_word(OP_ADD, 32'd16 + 32'(m) * 4, 3'(m), 1'b1, 32'd0);
        send_word(OP_ADD, 32'd0, EASE_QUAD_IN, 1'b1, 32'd0);
        send_word(OP_GAP, 32'd6, EASE_LINEAR, 1'b0, 32'd0);
        send_word(OP_WAIT, 32'd0, EASE_LINEAR, 1'b0, 32'd0);
        send_word(OP_ADD, 32'd40, EASE_CUBIC, 1'b0, 32'd0);
    endtask

    // Walk through the timeline forward, past the end and back.
    task automatic test_directed_seek();
        send_word(OP_ADVANCE, 32'd0, EASE_LINEAR, 1'b0, 32'd0);
        send_word(OP_ADVANCE, 32'd0, EASE_LINEAR, 1'b0, 32'd9);
        send_word(OP_ADVANCE, 32'd0, EASE_LINEAR, 1'b0, 32'd20);
        send_word(OP_SCRUB, 32'd0, EASE_LINEAR, 1'b0, 32'd100);
        send_word(OP_SCRUB, 32'd0, EASE_LINEAR, 1'b0, 32'd12);
        send_word(OP_ADVANCE, 32'd0, EASE_LINEAR, 1'b0, 32'hFFFF_FFFF);
        send_word(OP_ADVANCE, 32'd0, EASE_LINEAR, 1'b0, 32'd1);
        send_word(OP_SCRUB, 32'd0, EASE_LINEAR, 1'b0, 32'd0);
    endtask

    // Mostly seeks over the populated range, with the odd add, gap or wait that fills the table and the odd spare code.
    task automatic test_random_words(int count);
        int          pick;
        logic [31:0] tv;
        logic [31:0] dur;
        for (int n = 0; n < count; n++) begin
            calm = (n >= 40 && n < 70);
            pick = $urandom_range(0, 99);
            dur = ($urandom_range(0, 19) == 0) ? $urandom : 32'($urandom_range(0, 60));
            if (pick < 12) begin
                send_word(3'($urandom_range(0, 2)), dur, 3'($urandom_range(0, 7)),
                          $urandom_range(0, 4) != 0, $urandom);
            end else if (pick < 55) begin
                tv = ($urandom_range(0, 19) == 0) ? $urandom : 32'($urandom_range(0, 30));
                send_word(OP_ADVANCE, $urandom, 3'($urandom), 1'($urandom), tv);
            end else if (pick < 97) begin
                if (total_ticks > 64'd100000 || $urandom_range(0, 19) == 0) tv = $urandom;
                else tv = 32'($urandom_range(0, 32'(total_ticks) + 40));
                send_word(OP_SCRUB, $urandom, 3'($urandom), 1'($urandom), tv);
            end else begin
                send_word(3'($urandom_range(5, 7)), $urandom, 3'($urandom), 1'($urandom),
                          $urandom);
            end
        end
        calm = 0;
    endtask

    initial begin
        words_sent = 0;
        error_words = 0;
        calm = 0;
        n_events = 0;
        next_pend = 0;
        n_live = 0;
        now_tick = 0;
        total_ticks = 0;
        i_rst_n <= 1'b0;
        i_valid <= 1'b0;
        i_operation <= OP_ADD;
        i_duration <= '0;
        i_ease_mode <= EASE_LINEAR;
        i_has_action <= 1'b0;
        i_time_value <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_timeline();
        test_build_timeline();
        test_directed_seek();
        test_random_words(94);
        i_valid <= 1'b0;

        while (expected_words.size() != 0) @(posedge i_clk);
        repeat (1000) @(posedge i_clk);

        $display("tb: %0d words sent, %0d result words checked, %0d error words,",
                 words_sent, words_checked, error_words);
        $display("tb: %0d events on the timeline, every easing mode and seek direction",
                 n_events);
        if (fails == 0 && expected_words.size() == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end

endmodule

FILE: eased_event_timeline_unit.f
sv/eet_pkg.sv
sv/eased_event_timeline_unit.sv
sv/eet_chk.sv
dv/tb.sv
